@@ sv/box_filter_3x3_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Box filter 3x3 assertion macros
// Shared concurrent assertion helpers, clocked on aclk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_UNIT_DEFINES_SVH
`define BOX_FILTER_3X3_UNIT_DEFINES_SVH

// cond holds in the same cycle as trig
`define BF3_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// cond holds in the cycle after trig
`define BF3_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ sv/bf3_pkg.sv @@
// ----------------------------------------------------------------------------
// Box filter 3x3 package
// Sizes, register codes, shared structs and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int PIX_W        = 8;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 12;
    localparam int CFG_W_W      = 11;
    localparam int CFG_H_W      = 13;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int QUOT_W       = 5;
    localparam int CSUM_W       = 7;
    localparam int MEAN_W       = 8;
    localparam int LINE_W       = 2 * PIX_W;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int M_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [ADDR_W-1:0] RESET_LAST_COL = ADDR_W'(640 - 1);
    localparam logic [ROW_W-1:0]  RESET_LAST_ROW = ROW_W'(480 - 1);

    typedef struct packed {
        logic              emit;
        logic              last;
        logic [ROW_W-1:0]  row_m1;
        logic [ADDR_W-1:0] col;
    } bf3_ctrl_t;

    typedef struct packed {
        logic              last;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [MEAN_W-1:0] mean;
    } bf3_result_t;

    // floor(x/9) for 8-bit x: x*57 >> 9 is exact over 0..255
    function automatic logic [QUOT_W-1:0] div9(input logic [PIX_W-1:0] x);
        logic [13:0] prod;
        prod = 14'(x) * 14'd57;
        return prod[13:9];
    endfunction

endpackage

@@ sv/box_filter_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// Box filter 3x3 unit
// Streaming 3x3 mean filter over an 8-bit raster with a two-row line store.
// ----------------------------------------------------------------------------
// One pixel is taken per clock in raster order while the result queue has
// room; each pixel at row r, column c with r >= 2 and c >= 2 yields one
// result for the centre (r-1, c-1), the sum of floor(tap/9) over nine taps.
// Border positions give no result. The sustained rate of one pixel per clock
// is set by the line store, which is read at intake and written back in the
// following cycle on a separate port. A four-deep result queue keeps intake
// running while results wait. Width and height are saturated to 3..1024 and
// 3..4096; writing either register restarts the frame at row 0, column 0.
// Configure only while no results are outstanding.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_unit_defines.svh"

module box_filter_3x3_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // [7:0] pixel_value
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] mean_value, [19:8] out_row, [29:20] out_col, [31:30] zero
    output logic [bf3_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [bf3_pkg::CFG_W_W-1:0] W_MIN = bf3_pkg::CFG_W_W'(3);
    localparam logic [bf3_pkg::CFG_W_W-1:0] W_MAX = bf3_pkg::CFG_W_W'(bf3_pkg::MAX_WIDTH);
    localparam logic [bf3_pkg::CFG_H_W-1:0] H_MIN = bf3_pkg::CFG_H_W'(3);
    localparam logic [bf3_pkg::CFG_H_W-1:0] H_MAX = bf3_pkg::CFG_H_W'(bf3_pkg::HEIGHT_LIMIT);

    logic [bf3_pkg::ADDR_W-1:0] col_reg, col_next;
    logic [bf3_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [bf3_pkg::ADDR_W-1:0] last_col_reg, last_col_next;
    logic [bf3_pkg::ROW_W-1:0]  last_row_reg, last_row_next;

    logic                        st_valid_reg;
    logic [bf3_pkg::PIX_W-1:0]   st_pixel_reg;
    bf3_pkg::bf3_ctrl_t          st_ctrl_reg, st_ctrl_next;

    logic                         in_xfer, cfg_xfer, cfg_hit;
    logic [bf3_pkg::CFG_W_W-1:0]  wval;
    logic [bf3_pkg::CFG_H_W-1:0]  hval;
    logic [3:0]                   inflight;

    logic [bf3_pkg::LINE_W-1:0]   line_rd_data;
    logic                         line_wr_en;
    logic [bf3_pkg::ADDR_W-1:0]   line_wr_addr;
    logic [bf3_pkg::LINE_W-1:0]   line_wr_data;
    logic                         res_valid;
    bf3_pkg::bf3_result_t         res, head;
    logic [bf3_pkg::FIFO_CNT_W-1:0] fifo_count;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_xfer && ((cfg_index == bf3_pkg::REG_IMAGE_WIDTH)
                                 || (cfg_index == bf3_pkg::REG_IMAGE_HEIGHT));

    // queue room for everything in flight plus the next pixel
    assign inflight = 4'(fifo_count) + 4'(st_valid_reg);
    assign s_tready = (inflight < 4'(bf3_pkg::FIFO_DEPTH));
    assign in_xfer  = s_tvalid && s_tready;

    assign wval = bf3_pkg::CFG_W_W'(cfg_data);
    assign hval = cfg_data;

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_xfer && cfg_index == bf3_pkg::REG_IMAGE_WIDTH) begin
            if (wval < W_MIN) begin
                last_col_next = bf3_pkg::ADDR_W'(2);
            end else if (wval > W_MAX) begin
                last_col_next = bf3_pkg::ADDR_W'(bf3_pkg::MAX_WIDTH - 1);
            end else begin
                last_col_next = bf3_pkg::ADDR_W'(wval - bf3_pkg::CFG_W_W'(1));
            end
        end
        if (cfg_xfer && cfg_index == bf3_pkg::REG_IMAGE_HEIGHT) begin
            if (hval < H_MIN) begin
                last_row_next = bf3_pkg::ROW_W'(2);
            end else if (hval > H_MAX) begin
                last_row_next = bf3_pkg::ROW_W'(bf3_pkg::HEIGHT_LIMIT - 1);
            end else begin
                last_row_next = bf3_pkg::ROW_W'(hval - bf3_pkg::CFG_H_W'(1));
            end
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (in_xfer) begin
            if (col_reg == last_col_reg) begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0
                                                     : row_reg + bf3_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + bf3_pkg::ADDR_W'(1);
            end
        end
    end

    always_comb begin
        st_ctrl_next.emit   = (row_reg >= bf3_pkg::ROW_W'(2))
                           && (col_reg >= bf3_pkg::ADDR_W'(2));
        st_ctrl_next.last   = (row_reg == last_row_reg) && (col_reg == last_col_reg);
        st_ctrl_next.row_m1 = row_reg - bf3_pkg::ROW_W'(1);
        st_ctrl_next.col    = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= bf3_pkg::RESET_LAST_COL;
            last_row_reg <= bf3_pkg::RESET_LAST_ROW;
            st_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            st_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            st_pixel_reg <= s_tdata;
            st_ctrl_reg  <= st_ctrl_next;
        end
    end

    bf3_line_ram u_line_ram (
        .aclk    (aclk),
        .rd_en   (in_xfer),
        .rd_addr (col_reg),
        .rd_data (line_rd_data),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data)
    );

    bf3_window u_window (
        .aclk         (aclk),
        .st_valid     (st_valid_reg),
        .st_pixel     (st_pixel_reg),
        .st_ctrl      (st_ctrl_reg),
        .line_rd_data (line_rd_data),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .res_valid    (res_valid),
        .res          (res)
    );

    bf3_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = {2'b00, head.col, head.row, head.mean};
    assign m_tlast = head.last;

    `BF3_ASSERT_SAME(a_no_overflow, 1'b1, inflight <= 4'(bf3_pkg::FIFO_DEPTH), "queue overrun")
    `BF3_ASSERT_NEXT(a_stage_follows, in_xfer, st_valid_reg, "stage lost a transfer")
    `BF3_ASSERT_SAME(a_last_is_emit, st_valid_reg && st_ctrl_reg.last, st_ctrl_reg.emit, "last on border")
    `BF3_ASSERT_NEXT(a_cfg_restart, cfg_hit, col_reg == '0 && row_reg == '0, "frame not restarted")

endmodule

@@ sv/bf3_line_ram.sv @@
// ----------------------------------------------------------------------------
// Box filter 3x3 line store
// One-read one-write synchronous RAM, one entry per column, holding the
// upper and middle rows side by side. Read data is registered.
// ----------------------------------------------------------------------------
module bf3_line_ram (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [bf3_pkg::ADDR_W-1:0]   rd_addr,
    output logic [bf3_pkg::LINE_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [bf3_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [bf3_pkg::LINE_W-1:0]   wr_data
);

    logic [bf3_pkg::LINE_W-1:0] mem [bf3_pkg::MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bf3_window.sv @@
// ----------------------------------------------------------------------------
// Box filter 3x3 window
// Holds the last two column sums of floor(tap/9), updates the line store
// with the shifted rows and forms the result for interior positions.
// ----------------------------------------------------------------------------
module bf3_window (
    input  logic                         aclk,
    input  logic                         st_valid,
    input  logic [bf3_pkg::PIX_W-1:0]    st_pixel,
    input  bf3_pkg::bf3_ctrl_t           st_ctrl,
    input  logic [bf3_pkg::LINE_W-1:0]   line_rd_data,
    output logic                         line_wr_en,
    output logic [bf3_pkg::ADDR_W-1:0]   line_wr_addr,
    output logic [bf3_pkg::LINE_W-1:0]   line_wr_data,
    output logic                         res_valid,
    output bf3_pkg::bf3_result_t         res
);

    logic [bf3_pkg::CSUM_W-1:0] csum1_reg, csum2_reg;
    logic [bf3_pkg::CSUM_W-1:0] csum_new;
    logic [bf3_pkg::PIX_W-1:0]  top_pix, mid_pix;

    // line word: upper row in the high byte, middle row in the low byte
    assign top_pix = line_rd_data[bf3_pkg::LINE_W-1:bf3_pkg::PIX_W];
    assign mid_pix = line_rd_data[bf3_pkg::PIX_W-1:0];

    assign csum_new = bf3_pkg::CSUM_W'(bf3_pkg::div9(top_pix))
                    + bf3_pkg::CSUM_W'(bf3_pkg::div9(mid_pix))
                    + bf3_pkg::CSUM_W'(bf3_pkg::div9(st_pixel));

    assign line_wr_en   = st_valid;
    assign line_wr_addr = st_ctrl.col;
    assign line_wr_data = {mid_pix, st_pixel};

    always_ff @(posedge aclk) begin
        if (st_valid) begin
            csum1_reg <= csum2_reg;
            csum2_reg <= csum_new;
        end
    end

    always_comb begin
        res_valid = st_valid && st_ctrl.emit;
        res.mean  = bf3_pkg::MEAN_W'(csum1_reg) + bf3_pkg::MEAN_W'(csum2_reg)
                  + bf3_pkg::MEAN_W'(csum_new);
        res.row   = st_ctrl.row_m1;
        res.col   = bf3_pkg::COL_W'(st_ctrl.col - bf3_pkg::ADDR_W'(1));
        res.last  = st_ctrl.last;
    end

endmodule

@@ sv/bf3_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Box filter 3x3 result queue
// Small register FIFO that decouples result transfers from pixel intake.
// ----------------------------------------------------------------------------
module bf3_out_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  bf3_pkg::bf3_result_t             push_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output bf3_pkg::bf3_result_t             head,
    output logic [bf3_pkg::FIFO_CNT_W-1:0]   count
);

    bf3_pkg::bf3_result_t entry [bf3_pkg::FIFO_DEPTH];

    logic [bf3_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bf3_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bf3_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           pop;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign head     = entry[rd_ptr_reg];
    assign count    = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + bf3_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + bf3_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + bf3_pkg::FIFO_CNT_W'(push)
                    - bf3_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Box filter 3x3 unit testbench
// Raster pixels enter on the slave stream with random gaps. A local window
// model predicts each interior mean with its row, column and end-of-frame
// flag, and every master stream transfer is checked against it under random
// back-pressure. Frame sizes change between phases on the register channel,
// covering saturated settings, the tallest frame height and restarts mid-frame.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned ITEM_TARGET = 750;
    localparam int unsigned QUIET_START = 600;

    typedef struct packed {
        logic [7:0]  mean;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } mean_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic [7:0]                     s_tdata   = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bf3_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    box_filter_3x3_unit DUT (.*);

    // window model state
    logic [7:0]  upper_row [bf3_pkg::MAX_WIDTH];
    logic [7:0]  middle_row [bf3_pkg::MAX_WIDTH];
    logic [7:0]  taps [9];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [10:0] width_reg  = 11'd640;
    logic [12:0] height_reg = 13'd480;

    logic [7:0]   pixel_queue [$];
    mean_result_t mean_queue [$];

    logic [7:0] corner_pixels [8] = '{8'd0, 8'd8, 8'd9, 8'd17, 8'd18, 8'd252, 8'd254, 8'd255};
    logic [7:0] mixed_frame [9]   = '{8'd8, 8'd9, 8'd17, 8'd18, 8'd26, 8'd27, 8'd0, 8'd255,
                                      8'd254};

    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned error_count     = 0;
    int          send_gap        = 0;
    int          hold_left       = 0;
    logic        quiet           = 1'b0;
    logic        long_hold_wanted = 1'b0;
    logic        long_hold_done   = 1'b0;

    initial begin
        foreach (taps[k]) taps[k] = 8'd0;
        foreach (upper_row[k]) begin
            upper_row[k]  = 8'd0;
            middle_row[k] = 8'd0;
        end
    end

    initial forever #4 aclk = ~aclk;

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned frame_width();
        if (width_reg < 3) return 3;
        if (width_reg > bf3_pkg::MAX_WIDTH) return bf3_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg < 3) return 3;
        if (height_reg > bf3_pkg::HEIGHT_LIMIT) return bf3_pkg::HEIGHT_LIMIT;
        return height_reg;
    endfunction

    function automatic void advance_window(input logic [7:0] px);
        int unsigned w, h, c, sum;
        mean_result_t res;
        w = frame_width();
        h = frame_height();
        c = (col_pos >= bf3_pkg::MAX_WIDTH) ? bf3_pkg::MAX_WIDTH - 1 : col_pos;
        for (int k = 0; k < 3; k++) begin
            taps[k*3]   = taps[k*3+1];
            taps[k*3+1] = taps[k*3+2];
        end
        taps[2] = upper_row[c];
        taps[5] = middle_row[c];
        taps[8] = px;
        upper_row[c]  = middle_row[c];
        middle_row[c] = px;
        if (row_pos >= 2 && c >= 2) begin
            sum = 0;
            foreach (taps[k]) sum += taps[k] / 9;
            res.mean = sum[7:0];
            res.row  = 12'(row_pos - 1);
            res.col  = 10'(c - 1);
            res.last = (row_pos == h - 1) && (c == w - 1);
            mean_queue.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        col_pos = c;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_mean(input logic [bf3_pkg::M_DATA_W-1:0] data,
                                       input logic last);
        mean_result_t want;
        if (mean_queue.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual tdata=%h tlast=%b",
                     $time, data, last);
            error_count++;
            return;
        end
        want = mean_queue.pop_front();
        results_checked++;
        compare_field("mean_value", want.mean, data[7:0]);
        compare_field("out_row", want.row, data[19:8]);
        compare_field("out_col", want.col, data[29:20]);
        compare_field("last_result", want.last, last);
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_window(s_tdata);
                pixels_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    s_tdata  <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_mean(m_tdata, m_tlast);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (long_hold_wanted && !long_hold_done && m_tvalid) begin
                long_hold_done <= 1'b1;
                hold_left      <= 96;
                m_tready       <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                hold_left <= $urandom_range(0, 6);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_pixel(input logic [7:0] px);
        pixel_queue.push_back(px);
        pixels_queued++;
    endtask

    function automatic logic [7:0] random_pixel();
        if ($urandom_range(0, 3) == 0) return corner_pixels[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random(input int unsigned count);
        repeat (count) push_pixel(random_pixel());
    endtask

    // wait until every pixel is in and every mean is out, then let border pixels settle
    task automatic drain();
        while (pixels_accepted != pixels_queued || mean_queue.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_register(input logic [bf3_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bf3_pkg::CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == bf3_pkg::REG_IMAGE_WIDTH) width_reg = value[10:0];
        else height_reg = value[12:0];
        col_pos = 0;
        row_pos = 0;
        reg_writes++;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned w_pick, h_pick, frames, count, limit;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset frame size: start of the first row, no results
        queue_random(24);
        drain();

        write_register(bf3_pkg::REG_IMAGE_WIDTH, 13'd3);
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd3);
        repeat (9) push_pixel(8'd255);
        foreach (mixed_frame[i]) push_pixel(mixed_frame[i]);
        drain();

        // sizes below the minimum saturate to 3
        write_register(bf3_pkg::REG_IMAGE_WIDTH, 13'd1);
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd2);
        queue_random(9);
        drain();

        // restart in the middle of a frame
        write_register(bf3_pkg::REG_IMAGE_WIDTH, 13'd4);
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd3);
        queue_random(7);
        drain();
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd3);
        queue_random(12);
        drain();

        // tallest frames, only the first rows
        write_register(bf3_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd4096);
        queue_random(18);
        drain();
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd8191);
        queue_random(9);
        drain();

        // width field masked to 4, long receiver stall fills the queue
        write_register(bf3_pkg::REG_IMAGE_WIDTH, 13'd2052);
        write_register(bf3_pkg::REG_IMAGE_HEIGHT, 13'd8);
        long_hold_wanted = 1'b1;
        queue_random(64);
        drain();

        while (pixels_queued < ITEM_TARGET) begin
            if (pixels_queued >= QUIET_START) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0:       w_pick = $urandom_range(0, 2);
                1:       w_pick = $urandom_range(13, 40);
                default: w_pick = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h_pick = $urandom_range(0, 2);
                1:       h_pick = $urandom_range(9, 16);
                default: h_pick = $urandom_range(3, 8);
            endcase
            case ($urandom_range(0, 3))
                0: write_register(bf3_pkg::REG_IMAGE_WIDTH, bf3_pkg::CFG_DATA_W'(w_pick));
                1: write_register(bf3_pkg::REG_IMAGE_HEIGHT, bf3_pkg::CFG_DATA_W'(h_pick));
                default: begin
                    write_register(bf3_pkg::REG_IMAGE_WIDTH, bf3_pkg::CFG_DATA_W'(w_pick));
                    write_register(bf3_pkg::REG_IMAGE_HEIGHT, bf3_pkg::CFG_DATA_W'(h_pick));
                end
            endcase
            count = frame_width() * frame_height();
            frames = (count > 100) ? 1 : $urandom_range(1, 3);
            count = frames * count;
            if ($urandom_range(0, 1) == 1) count += $urandom_range(0, 2 * frame_width());
            limit = (pixels_queued < QUIET_START) ? QUIET_START : ITEM_TARGET;
            if (count > limit - pixels_queued) count = limit - pixels_queued;
            queue_random(count);
            drain();
        end

        $display("Run covered %0d pixels, %0d checked results and %0d register writes,",
                 pixels_accepted, results_checked, reg_writes);
        $display("frames up to 40 wide and 4096 high, masking, saturation and restarts.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
